// ----- rtl/core/jet_pkg.sv -----
// ----------------------------------------------------------------------------
// jet_pkg
// Shared types, constants and helpers for the Julia set escape-time core.
// ----------------------------------------------------------------------------
package jet_pkg;

    // Fixed-point format and field widths.
    localparam int FRAC_BITS  = 28;
    localparam int COORD_BITS = 8;
    localparam int Q_W        = 32;
    localparam int PROD_W     = 2 * Q_W;
    localparam int CNT_W      = 8;
    localparam int DIM_W      = 9;
    localparam int SCALE_W    = 31;
    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Escape bound: |z|^2 compared against 4.0 at double fraction width.
    localparam logic [PROD_W-1:0] MAG_LIMIT = PROD_W'(4) << (2 * FRAC_BITS);

    // Register reset values.
    localparam logic signed [Q_W-1:0] RST_C_REAL       = -32'sd187904819;
    localparam logic signed [Q_W-1:0] RST_C_IMAG       = 32'sd72477573;
    localparam logic [SCALE_W-1:0]    RST_PIXEL_SCALE  = 31'd12582912;
    localparam logic [DIM_W-1:0]      RST_IMAGE_WIDTH  = 9'd64;
    localparam logic [DIM_W-1:0]      RST_IMAGE_HEIGHT = 9'd32;
    localparam logic [CNT_W-1:0]      RST_MAX_ITER     = 8'd100;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_C_REAL       = 3'd0,
        REG_C_IMAG       = 3'd1,
        REG_PIXEL_SCALE  = 3'd2,
        REG_IMAGE_WIDTH  = 3'd3,
        REG_IMAGE_HEIGHT = 3'd4,
        REG_MAX_ITER     = 3'd5
    } t_cfg_reg;

    // Input and result payloads.
    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } t_in_item;

    typedef struct packed {
        logic [CNT_W-1:0]      iterations;
        logic                  escaped;
        logic signed [Q_W-1:0] z_real;
        logic signed [Q_W-1:0] z_imag;
    } t_out_item;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP_X,
        S_MAP_Y,
        S_MUL_RR,
        S_MUL_II,
        S_MUL_RI,
        S_STEP,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_pixel;
        logic map_x;
        logic map_y;
        logic mul_rr;
        logic mul_ii;
        logic mul_ri;
        logic step;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic go_on;
        logic out_free;
    } t_dp_status;

    // Saturate a wide signed value to the Q format range.
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        logic signed [Q_W-1:0]    r;
        hi = PROD_W'({1'b0, {(Q_W-1){1'b1}}});
        lo = -hi - PROD_W'(1);
        if (v > hi) begin
            r = {1'b0, {(Q_W-1){1'b1}}};
        end else if (v < lo) begin
            r = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/jet_ctrl.sv -----
// ----------------------------------------------------------------------------
// jet_ctrl
// Sequencer for the escape-time core: coordinate mapping, then three shared
// multiplies and one update per iteration, then the result hand-off.
// ----------------------------------------------------------------------------
module jet_ctrl import jet_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_pixel = 1'b1;
                    n_state          = S_MAP_X;
                end
            end
            S_MAP_X: begin
                o_cmd.map_x = 1'b1;
                n_state     = S_MAP_Y;
            end
            S_MAP_Y: begin
                o_cmd.map_y = 1'b1;
                n_state     = S_MUL_RR;
            end
            S_MUL_RR: begin
                o_cmd.mul_rr = 1'b1;
                n_state      = S_MUL_II;
            end
            S_MUL_II: begin
                o_cmd.mul_ii = 1'b1;
                n_state      = S_MUL_RI;
            end
            S_MUL_RI: begin
                o_cmd.mul_ri = 1'b1;
                n_state      = S_STEP;
            end
            S_STEP: begin
                // The datapath only updates z when the loop goes on.
                o_cmd.step = i_status.go_on;
                n_state    = i_status.go_on ? S_MUL_RR : S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/jet_datapath.sv -----
// ----------------------------------------------------------------------------
// jet_datapath
// Configuration registers, the shared 32x32 multiplier, the z and count
// registers, and the result output register.
// ----------------------------------------------------------------------------
module jet_datapath import jet_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_in_data,
    input  t_dp_cmd               i_cmd,
    input  logic                  i_out_stall,
    output t_dp_status            o_status,
    output logic                  o_out_valid,
    output t_out_item             o_out_data
);

    // Configuration registers.
    logic signed [Q_W-1:0]  r_c_real;
    logic signed [Q_W-1:0]  r_c_imag;
    logic [SCALE_W-1:0]     r_pixel_scale;
    logic [DIM_W-1:0]       r_image_width;
    logic [DIM_W-1:0]       r_image_height;
    logic [CNT_W-1:0]       r_max_iter;

    // Working registers.
    logic [COORD_BITS-1:0]    r_px;
    logic [COORD_BITS-1:0]    r_py;
    logic signed [Q_W-1:0]    r_zr;
    logic signed [Q_W-1:0]    r_zi;
    logic signed [PROD_W-1:0] r_rr;
    logic signed [PROD_W-1:0] r_ii;
    logic signed [PROD_W-1:0] r_ri;
    logic signed [PROD_W-1:0] r_diff;
    logic [PROD_W-1:0]        r_mag;
    logic [CNT_W-1:0]         r_count;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic signed [Q_W-1:0]    dx;
    logic signed [Q_W-1:0]    dy;
    logic signed [Q_W-1:0]    scale_s;
    logic signed [Q_W-1:0]    mul_a;
    logic signed [Q_W-1:0]    mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] next_re;
    logic signed [PROD_W-1:0] next_im;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_real       <= RST_C_REAL;
            r_c_imag       <= RST_C_IMAG;
            r_pixel_scale  <= RST_PIXEL_SCALE;
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
            r_max_iter     <= RST_MAX_ITER;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_C_REAL:       r_c_real       <= i_cfg_data[Q_W-1:0];
                REG_C_IMAG:       r_c_imag       <= i_cfg_data[Q_W-1:0];
                REG_PIXEL_SCALE:  r_pixel_scale  <= i_cfg_data[SCALE_W-1:0];
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[DIM_W-1:0];
                REG_MAX_ITER:     r_max_iter     <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Offsets from the image center, 2*p - size.
    assign dx = $signed({{(Q_W-COORD_BITS-1){1'b0}}, r_px, 1'b0})
              - $signed({{(Q_W-DIM_W){1'b0}}, r_image_width});
    assign dy = $signed({{(Q_W-COORD_BITS-1){1'b0}}, r_py, 1'b0})
              - $signed({{(Q_W-DIM_W){1'b0}}, r_image_height});
    assign scale_s = $signed({1'b0, r_pixel_scale});

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = r_zr;
        mul_b = r_zr;
        if (i_cmd.map_x) begin
            mul_a = dx;
            mul_b = scale_s;
        end else if (i_cmd.map_y) begin
            mul_a = dy;
            mul_b = scale_s;
        end else if (i_cmd.mul_ii) begin
            mul_a = r_zi;
            mul_b = r_zi;
        end else if (i_cmd.mul_ri) begin
            mul_a = r_zr;
            mul_b = r_zi;
        end
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Next z parts: floor shift of the products, plus c.
    assign next_re = (r_diff >>> FRAC_BITS) + PROD_W'(r_c_real);
    assign next_im = (r_ri >>> (FRAC_BITS - 1)) + PROD_W'(r_c_imag);

    // Iteration registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pixel) begin
            r_px <= i_in_data.pixel_x[COORD_BITS-1:0];
            r_py <= i_in_data.pixel_y[COORD_BITS-1:0];
        end
        if (i_cmd.map_x) begin
            r_zr <= sat_q(prod);
        end
        if (i_cmd.map_y) begin
            r_zi    <= sat_q(prod);
            r_count <= '0;
        end
        if (i_cmd.mul_rr) begin
            r_rr <= prod;
        end
        if (i_cmd.mul_ii) begin
            r_ii <= prod;
        end
        if (i_cmd.mul_ri) begin
            r_ri   <= prod;
            r_mag  <= $unsigned(r_rr) + $unsigned(r_ii);
            r_diff <= r_rr - r_ii;
        end
        if (i_cmd.step) begin
            r_zr    <= sat_q(next_re);
            r_zi    <= sat_q(next_im);
            r_count <= r_count + CNT_W'(1);
        end
    end

    // The loop goes on while the count is below the limit and |z|^2 < 4.
    assign o_status.go_on    = (r_count < r_max_iter) && (r_mag < MAG_LIMIT);
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    // Result output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.iterations <= r_count;
            r_out.escaped    <= r_count < r_max_iter;
            r_out.z_real     <= r_zr;
            r_out.z_imag     <= r_zi;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/core/julia_escape_time_core.sv -----
// ----------------------------------------------------------------------------
// julia_escape_time_core
// Julia set escape-time evaluator: maps one pixel to z0 and iterates
// z = z*z + c in Q4.28 until |z|^2 reaches 4 or the iteration limit.
//
//   Channel  Direction  Handshake              Payload
//   in       input      i_in_valid/o_in_stall  i_in_data  (t_in_item)
//   out      output     o_out_valid/i_out_stall o_out_data (t_out_item)
//   cfg      input      i_cfg_we               i_cfg_index, i_cfg_data
//
// A pixel passes from acceptance through MAP_X and MAP_Y, then per iteration
// through MUL_RR, MUL_II, MUL_RI and STEP, then to DONE and the result register.
// One shared 32x32 multiplier forms zr*zr, zi*zi and zr*zi in turn.
// Synchronous reset restores the register reset values and empties the core.
// A new pixel is taken while a finished result still waits in the output
// register; a stalled output holds the following result in the core.
// ----------------------------------------------------------------------------
module julia_escape_time_core import jet_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;

    // Sequencer.
    jet_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // Arithmetic and storage.
    jet_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign o_in_stall = !in_ready;

endmodule

// ----- rtl/core/jet_checker.sv -----
// ----------------------------------------------------------------------------
// jet_checker
// Port-level checks for the escape-time core, bound to the top level.
// ----------------------------------------------------------------------------
module jet_checker import jet_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // After a transaction is accepted the core is busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("core took no time for an accepted pixel");

    // No result can appear in the cycle right after an accepted pixel.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !$rose(o_out_valid))
        else $error("result appeared too early");

    // Reset leaves the core empty and ready.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("core not empty after reset");

endmodule

bind julia_escape_time_core jet_checker u_jet_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
